/* rtl/core/ubxfp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ubxfp_pkg;

  localparam logic [7:0]  SYNC_CHAR_1           = 8'hB5;
  localparam logic [7:0]  SYNC_CHAR_2           = 8'h62;
  localparam logic [15:0] MAX_LENGTH_RESET      = 16'd93;
  localparam int          PAYLOAD_BYTES_DEFAULT = 128;
  localparam int          QUEUE_DEPTH           = 2;

  typedef enum logic {
    OP_RECV = 1'b0,
    OP_READ = 1'b1
  } op_t;

  // One classified item on its way from the front queue to the back end
  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic [6:0] offset;
    logic [2:0] nbytes;   // 0 to 4 bytes after clamping
    logic       sgn;
  } cmd_t;

endpackage

`default_nettype wire

/* rtl/core/ubxfp_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module ubxfp_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic            op,
  input  wire logic [7:0]      in_byte,
  input  wire logic [6:0]      field_offset,
  input  wire logic [2:0]      field_size,
  input  wire logic            field_signed,
  output logic                 cmd_valid,
  output ubxfp_pkg::cmd_t      cmd,
  input  wire logic            cmd_pop
);
  import ubxfp_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          entry [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] count;
  cmd_t          classified;
  logic          push;
  logic          pop;

  always_comb begin
    classified.op     = op ? OP_READ : OP_RECV;
    classified.data   = in_byte;
    classified.offset = field_offset;
    classified.sgn    = field_signed;
    // clamp odd sizes: nothing for zero, four bytes beyond four
    priority if (field_size == 3'd0) begin
      classified.nbytes = 3'd0;
    end else if (field_size > 3'd4) begin
      classified.nbytes = 3'd4;
    end else begin
      classified.nbytes = field_size;
    end
  end

  assign in_stall  = (count == NW'(QUEUE_DEPTH));
  assign push      = in_valid && !in_stall;
  assign pop       = cmd_pop;
  assign cmd_valid = (count != '0);
  assign cmd       = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= NW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("pop from empty queue");

  a_fill: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count did not follow a push");

endmodule

`default_nettype wire

/* rtl/core/ubxfp_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module ubxfp_back #(
  parameter int PAYLOAD_BYTES = ubxfp_pkg::PAYLOAD_BYTES_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cmd_valid,
  input  wire ubxfp_pkg::cmd_t    cmd,
  output logic                    cmd_pop,
  input  wire logic [15:0]        max_length,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    frame_good,
  output logic [7:0]              msg_class,
  output logic [7:0]              msg_id,
  output logic [15:0]             msg_length,
  output logic signed [32:0]      field_value
);
  import ubxfp_pkg::*;

  localparam int ROWS = (PAYLOAD_BYTES + 3) / 4;
  localparam int RW   = $clog2(ROWS);
  localparam int CW   = $clog2(PAYLOAD_BYTES + 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SYNC1, ST_SYNC2, ST_CLASS, ST_ID, ST_LEN1, ST_BODY, ST_CKA, ST_CKB
  } state_t;

  state_t          st;
  logic [7:0]      hdr_class;
  logic [7:0]      hdr_id;
  logic [15:0]     hdr_length;
  logic [7:0]      sum_a;
  logic [7:0]      sum_b;
  logic [CW-1:0]   byte_count;

  logic            adv;
  logic            take;
  logic            rd;
  logic [7:0]      b;
  logic [7:0]      sum_a_next;
  logic [7:0]      sum_b_next;
  logic [15:0]     length_next;
  logic [CW-1:0]   count_next;
  logic            count_fits;
  logic            wr_en;
  logic [RW-1:0]   wr_row;
  logic [1:0]      wr_lane;

  logic [3:0][RW-1:0] rd_row;
  logic [3:0]         in_range;

  // second stage: read data and field description
  logic               s2_valid;
  logic               s2_good;
  logic               s2_read;
  logic [1:0]         s2_lane;
  logic [2:0]         s2_nbytes;
  logic               s2_sgn;
  logic [3:0]         s2_in_range;
  logic [3:0][7:0]    rd_word;

  logic [31:0]        rotated;
  logic [31:0]        raw;
  logic signed [32:0] fv;
  logic               ext;

  assign adv     = !out_valid || !out_stall;
  assign cmd_pop = adv && cmd_valid;
  assign take    = cmd_pop && (cmd.op == OP_RECV);
  assign rd      = cmd_pop && (cmd.op == OP_READ);
  assign b       = cmd.data;

  assign sum_a_next  = sum_a + b;
  assign sum_b_next  = sum_b + sum_a_next;
  assign length_next = {b, hdr_length[7:0]};
  assign count_next  = byte_count + 1'b1;
  assign count_fits  = byte_count < CW'(PAYLOAD_BYTES);

  assign wr_en   = take && (st == ST_BODY) && count_fits;
  assign wr_row  = RW'(byte_count >> 2);
  assign wr_lane = byte_count[1:0];

  always_comb begin
    logic [1:0] dk;
    logic [7:0] addr;
    for (int j = 0; j < 4; j++) begin
      dk          = 2'(j) - cmd.offset[1:0];
      addr        = {1'b0, cmd.offset} + {6'b0, dk};
      rd_row[j]   = RW'(addr[7:2]);
      addr        = {1'b0, cmd.offset} + 8'(j);
      in_range[j] = 32'(addr) < PAYLOAD_BYTES;
    end
  end

  // four byte-wide banks, one per address lane; any 4-byte window hits each once
  for (genvar j = 0; j < 4; j++) begin : g_bank
    logic [7:0] mem [ROWS];

    always_ff @(posedge clk) begin
      if (wr_en && (wr_lane == 2'(j))) begin
        mem[wr_row] <= b;
      end
      if (rd) begin
        rd_word[j] <= mem[rd_row[j]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= ST_IDLE;
      hdr_class  <= '0;
      hdr_id     <= '0;
      hdr_length <= '0;
      sum_a      <= '0;
      sum_b      <= '0;
      byte_count <= '0;
      s2_valid   <= 1'b0;
      s2_good    <= 1'b0;
    end else if (adv) begin
      s2_valid <= cmd_valid;
      s2_good  <= 1'b0;
      if (take) begin
        unique case (st)
          ST_IDLE: begin
            if (b == SYNC_CHAR_1) st <= ST_SYNC1;
          end
          ST_SYNC1: begin
            if (b == SYNC_CHAR_2) begin
              st    <= ST_SYNC2;
              sum_a <= '0;
              sum_b <= '0;
            end else begin
              st <= ST_IDLE;
            end
          end
          ST_SYNC2: begin
            hdr_class <= b;
            sum_a     <= sum_a_next;
            sum_b     <= sum_b_next;
            st        <= ST_CLASS;
          end
          ST_CLASS: begin
            hdr_id <= b;
            sum_a  <= sum_a_next;
            sum_b  <= sum_b_next;
            st     <= ST_ID;
          end
          ST_ID: begin
            hdr_length <= {8'h00, b};
            sum_a      <= sum_a_next;
            sum_b      <= sum_b_next;
            st         <= ST_LEN1;
          end
          ST_LEN1: begin
            hdr_length <= length_next;
            if (length_next < max_length) begin
              sum_a      <= sum_a_next;
              sum_b      <= sum_b_next;
              byte_count <= '0;
              st         <= (length_next == '0) ? ST_CKA : ST_BODY;
            end else begin
              st <= ST_IDLE;
            end
          end
          ST_BODY: begin
            if (count_fits) begin
              sum_a      <= sum_a_next;
              sum_b      <= sum_b_next;
              byte_count <= count_next;
              if (16'(count_next) == hdr_length) st <= ST_CKA;
            end else begin
              // overrun: drop the frame
              st <= ST_IDLE;
            end
          end
          ST_CKA: begin
            st <= (b == sum_a) ? ST_CKB : ST_IDLE;
          end
          ST_CKB: begin
            s2_good <= (b == sum_b);
            st      <= ST_IDLE;
          end
          default: begin
            st <= ST_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_read     <= rd;
      s2_lane     <= cmd.offset[1:0];
      s2_nbytes   <= cmd.nbytes;
      s2_sgn      <= cmd.sgn;
      s2_in_range <= in_range;
    end
  end

  // bring the lane holding the first field byte down to bits 7:0
  assign rotated = 32'({rd_word, rd_word} >> {s2_lane, 3'b000});

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      raw[8*k +: 8] = (s2_in_range[k] && (3'(k) < s2_nbytes)) ? rotated[8*k +: 8] : 8'h00;
    end
    ext = 1'b0;
    fv  = '0;
    unique case (s2_nbytes)
      3'd1: begin
        ext = s2_sgn && raw[7];
        fv  = {{25{ext}}, raw[7:0]};
      end
      3'd2: begin
        ext = s2_sgn && raw[15];
        fv  = {{17{ext}}, raw[15:0]};
      end
      3'd3: begin
        ext = s2_sgn && raw[23];
        fv  = {{9{ext}}, raw[23:0]};
      end
      3'd4: begin
        ext = s2_sgn && raw[31];
        fv  = {ext, raw};
      end
      default: begin
        fv = '0;
      end
    endcase
  end

  // header registers hold the state after the second-stage item here
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      frame_good  <= s2_good;
      msg_class   <= hdr_class;
      msg_id      <= hdr_id;
      msg_length  <= hdr_length;
      field_value <= s2_read ? fv : '0;
    end
  end

  a_good_no_field: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_good |-> field_value == '0)
    else $error("good frame word carries a field value");

  a_body_count: assert property (@(posedge clk) disable iff (rst)
    st == ST_BODY |-> hdr_length > 16'(byte_count))
    else $error("payload count reached length without leaving body");

  a_ckb_done: assert property (@(posedge clk) disable iff (rst)
    take && st == ST_CKB |=> st == ST_IDLE)
    else $error("parser did not return to idle after checksum");

endmodule

`default_nettype wire

/* rtl/core/ubx_frame_parser.sv */
`timescale 1ns / 1ps
`default_nettype none

// UBX frame receiver with payload field reader. Each word is either a stream
// byte (op 0) or a little-endian field read of up to 4 payload bytes (op 1).
// One word is taken per cycle while the output is not stalled; a result passes
// through the input queue, the second-stage registers and the output registers.
// A short input queue feeds the parser, and the payload store is four byte-wide
// banks so a whole field is read in one access, with a single read port per bank.
// Nothing needs clearing after reset, and max_length may be written whenever idle.
module ubx_frame_parser #(
  parameter int PAYLOAD_BYTES = ubxfp_pkg::PAYLOAD_BYTES_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               op,
  input  wire logic [7:0]         in_byte,
  input  wire logic [6:0]         field_offset,
  input  wire logic [2:0]         field_size,
  input  wire logic               field_signed,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    frame_good,
  output logic [7:0]              msg_class,
  output logic [7:0]              msg_id,
  output logic [15:0]             msg_length,
  output logic signed [32:0]      field_value,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [15:0]        cfg_max_length
);
  import ubxfp_pkg::*;

  logic        cmd_valid;
  cmd_t        cmd;
  logic        cmd_pop;
  logic [15:0] max_length;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MAX_LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_length <= cfg_max_length;
    end
  end

  ubxfp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .in_byte      (in_byte),
    .field_offset (field_offset),
    .field_size   (field_size),
    .field_signed (field_signed),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop)
  );

  ubxfp_back #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop),
    .max_length  (max_length),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .frame_good  (frame_good),
    .msg_class   (msg_class),
    .msg_id      (msg_id),
    .msg_length  (msg_length),
    .field_value (field_value)
  );

endmodule

`default_nettype wire

/* dv/ubx_frame_parser_tb.sv */
`timescale 1ns / 1ps

module ubx_frame_parser_tb;
  import ubxfp_pkg::*;

  localparam int PAYLOAD     = PAYLOAD_BYTES_DEFAULT;
  localparam int HOLD_CYCLES = 48;
  localparam int STALL_LIMIT = 2000;

  typedef enum int {
    PS_IDLE, PS_SYNC1, PS_SYNC2, PS_CLASS, PS_ID, PS_LEN1, PS_BODY, PS_CKA, PS_CKB
  } parse_t;

  typedef enum int {
    FK_GOOD, FK_BAD_CKA, FK_BAD_CKB, FK_REJECT, FK_OVERRUN, FK_CUT
  } frame_kind_t;

  typedef struct {
    op_t        op;
    logic [7:0] data;
    logic [6:0] off;
    logic [2:0] size;
    logic       sgn;
  } word_t;

  typedef struct {
    logic        good;
    logic [7:0]  cls;
    logic [7:0]  id;
    logic [15:0] len;
    logic [32:0] value;
  } reply_t;

  // Tracks the parser and payload store, and holds the replies still owed
  class ubx_rx_tracker;
    logic [15:0] max_len;
    parse_t      pstate;
    logic [7:0]  cls, id, sum_a, sum_b;
    logic [15:0] len;
    int unsigned count;
    logic [7:0]  store [PAYLOAD];
    int          top_written;
    reply_t      replies_due [$];
    int          errors, good_frames, reads;

    function new();
      max_len     = MAX_LENGTH_RESET;
      pstate      = PS_IDLE;
      cls         = '0;
      id          = '0;
      sum_a       = '0;
      sum_b       = '0;
      len         = '0;
      count       = 0;
      top_written = -1;
      errors      = 0;
      good_frames = 0;
      reads       = 0;
      foreach (store[i]) store[i] = '0;
    endfunction

    function void fold(logic [7:0] b);
      sum_a = sum_a + b;
      sum_b = sum_b + sum_a;
    endfunction

    function bit step_byte(logic [7:0] b);
      bit good;
      good = 1'b0;
      case (pstate)
        PS_IDLE: if (b == SYNC_CHAR_1) pstate = PS_SYNC1;
        PS_SYNC1: begin
          if (b == SYNC_CHAR_2) begin
            pstate = PS_SYNC2;
            sum_a  = '0;
            sum_b  = '0;
          end else begin
            pstate = PS_IDLE;
          end
        end
        PS_SYNC2: begin
          cls = b;
          fold(b);
          pstate = PS_CLASS;
        end
        PS_CLASS: begin
          id = b;
          fold(b);
          pstate = PS_ID;
        end
        PS_ID: begin
          len = {8'h00, b};
          fold(b);
          pstate = PS_LEN1;
        end
        PS_LEN1: begin
          len[15:8] = b;
          // length register keeps the declared value even when rejected
          if (len < max_len) begin
            fold(b);
            count  = 0;
            pstate = (len == 16'd0) ? PS_CKA : PS_BODY;
          end else begin
            pstate = PS_IDLE;
          end
        end
        PS_BODY: begin
          if (count < PAYLOAD) begin
            fold(b);
            store[count] = b;
            if (int'(count) > top_written) top_written = int'(count);
            count++;
            if (count == len) pstate = PS_CKA;
          end else begin
            pstate = PS_IDLE;  // overrun: drop the word and resync
          end
        end
        PS_CKA: pstate = (b == sum_a) ? PS_CKB : PS_IDLE;
        PS_CKB: begin
          pstate = PS_IDLE;
          good   = (b == sum_b);
        end
        default: pstate = PS_IDLE;
      endcase
      return good;
    endfunction

    function logic [32:0] field_of(logic [6:0] off, logic [2:0] size, logic sgn);
      logic [32:0] v;
      int          n, a;
      v = '0;
      n = (size > 3'd4) ? 4 : int'(size);
      for (int k = 0; k < n; k++) begin
        a = int'(off) + k;
        if (a < PAYLOAD) v[8*k +: 8] = store[a];
      end
      if (n != 0 && sgn && v[8*n-1]) begin
        for (int k = 8 * n; k < 33; k++) v[k] = 1'b1;
      end
      return v;
    endfunction

    function void accept_word(word_t w);
      reply_t r;
      r.good  = 1'b0;
      r.value = '0;
      if (w.op == OP_RECV) begin
        r.good = step_byte(w.data);
        if (r.good) good_frames++;
      end else begin
        r.value = field_of(w.off, w.size, w.sgn);
        reads++;
      end
      r.cls = cls;
      r.id  = id;
      r.len = len;
      replies_due.push_back(r);
    endfunction

    function void check_reply(logic good, logic [7:0] c, logic [7:0] i, logic [15:0] l,
                              logic [32:0] v);
      reply_t e;
      if (replies_due.size() == 0) begin
        $display("%0t: result with nothing outstanding (good %b class %h id %h)",
                 $time, good, c, i);
        errors++;
        return;
      end
      e = replies_due.pop_front();
      if (good !== e.good) begin
        $display("%0t: frame_good expected %b actual %b", $time, e.good, good);
        errors++;
      end
      if (c !== e.cls) begin
        $display("%0t: msg_class expected %h actual %h", $time, e.cls, c);
        errors++;
      end
      if (i !== e.id) begin
        $display("%0t: msg_id expected %h actual %h", $time, e.id, i);
        errors++;
      end
      if (l !== e.len) begin
        $display("%0t: msg_length expected %h actual %h", $time, e.len, l);
        errors++;
      end
      if (v !== e.value) begin
        $display("%0t: field_value expected %h actual %h", $time, e.value, v);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  op_t                word_op;
  logic [7:0]         in_byte;
  logic [6:0]         field_offset;
  logic [2:0]         field_size;
  logic               field_signed;
  logic               out_valid;
  logic               out_stall;
  logic               frame_good;
  logic [7:0]         msg_class;
  logic [7:0]         msg_id;
  logic [15:0]        msg_length;
  logic signed [32:0] field_value;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [15:0]        cfg_max_length;

  ubx_rx_tracker sb = new();
  bit            calm = 1'b0;
  int            holds_asked = 0;
  int            holds_done = 0;
  int            sent = 0;
  int            settings = 0;

  ubx_frame_parser #(.PAYLOAD_BYTES(PAYLOAD)) dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .op             (word_op),
    .in_byte        (in_byte),
    .field_offset   (field_offset),
    .field_size     (field_size),
    .field_signed   (field_signed),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .frame_good     (frame_good),
    .msg_class      (msg_class),
    .msg_id         (msg_id),
    .msg_length     (msg_length),
    .field_value    (field_value),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_max_length (cfg_max_length)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one word and hold it until taken
  task automatic send_word(input word_t w);
    int gap;
    if (!calm && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    word_op      <= w.op;
    in_byte      <= w.data;
    field_offset <= w.off;
    field_size   <= w.size;
    field_signed <= w.sgn;
    do @(posedge clk); while (in_stall);
    sb.accept_word(w);
    sent++;
  endtask

  task automatic recv(input logic [7:0] b);
    word_t w;
    w.op   = OP_RECV;
    w.data = b;
    w.off  = 7'($urandom);
    w.size = 3'($urandom);
    w.sgn  = 1'($urandom);
    send_word(w);
  endtask

  task automatic read_at(input logic [6:0] off, input logic [2:0] size, input logic sgn);
    word_t w;
    w.op   = OP_READ;
    w.data = 8'($urandom);
    w.off  = off;
    w.size = size;
    w.sgn  = sgn;
    send_word(w);
  endtask

  // Random field read touching only payload bytes already written
  function automatic word_t pick_read();
    word_t w;
    int    n, a;
    bit    ok;
    w.op   = OP_READ;
    w.data = 8'($urandom);
    for (int t = 0; t < 16; t++) begin
      if (sb.top_written >= 0 && $urandom_range(0, 3) != 0)
        w.off = 7'($urandom_range(0, sb.top_written));
      else
        w.off = 7'($urandom_range(0, 127));
      w.size = 3'($urandom_range(0, 7));
      w.sgn  = 1'($urandom);
      n  = (w.size > 3'd4) ? 4 : int'(w.size);
      ok = 1'b1;
      for (int k = 0; k < n; k++) begin
        a = int'(w.off) + k;
        if (a < PAYLOAD && a > sb.top_written) ok = 1'b0;
      end
      if (ok) return w;
    end
    w.size = 3'd0;
    return w;
  endfunction

  task automatic send_frame(input frame_kind_t kind, input logic [15:0] length,
                            input logic [7:0] cls, input logic [7:0] id, input bit mixed);
    logic [7:0] body [$];
    logic [7:0] ca, cb;
    int         npay, nkeep;
    ca   = '0;
    cb   = '0;
    body = {cls, id, length[7:0], length[15:8]};
    if (kind != FK_REJECT) begin
      npay = (kind == FK_OVERRUN) ? PAYLOAD + 1 : int'(length);
      repeat (npay) body.push_back(8'($urandom_range(0, 255)));
    end
    nkeep = (kind == FK_CUT) ? $urandom_range(0, body.size()) : body.size();
    foreach (body[i]) begin
      ca = ca + body[i];
      cb = cb + ca;
    end
    recv(SYNC_CHAR_1);
    recv(SYNC_CHAR_2);
    for (int i = 0; i < nkeep; i++) begin
      if (mixed && $urandom_range(0, 11) == 0) send_word(pick_read());
      recv(body[i]);
    end
    case (kind)
      FK_GOOD: begin
        recv(ca);
        recv(cb);
      end
      FK_BAD_CKA: begin
        recv(ca ^ 8'($urandom_range(1, 255)));
        recv(cb);
      end
      FK_BAD_CKB: begin
        recv(ca);
        recv(cb ^ 8'($urandom_range(1, 255)));
      end
      default: ;
    endcase
  endtask

  task automatic run_traffic(input int n);
    int          stop_at, pick, lim, top, nlen;
    logic [15:0] flen;
    stop_at = sent + n;
    while (sent < stop_at) begin
      pick = $urandom_range(0, 99);
      lim  = int'(sb.max_len) - 1;
      top  = (lim > PAYLOAD) ? PAYLOAD : lim;
      if ($urandom_range(0, 15) == 0) nlen = $urandom_range(0, top);
      else nlen = $urandom_range(0, (top > 24) ? 24 : top);
      flen = 16'(nlen);
      if (pick < 45 || (pick >= 65 && pick < 67 && sb.max_len <= 16'd129)) begin
        send_frame(FK_GOOD, flen, 8'($urandom), 8'($urandom), 1'b1);
      end else if (pick < 52) begin
        send_frame(FK_BAD_CKA, flen, 8'($urandom), 8'($urandom), 1'b1);
      end else if (pick < 59) begin
        send_frame(FK_BAD_CKB, flen, 8'($urandom), 8'($urandom), 1'b1);
      end else if (pick < 65) begin
        flen = 16'($urandom_range(sb.max_len, 16'hFFFF));
        send_frame(FK_REJECT, flen, 8'($urandom), 8'($urandom), 1'b1);
      end else if (pick < 67) begin
        flen = 16'($urandom_range(PAYLOAD + 1, (lim > 300) ? 300 : lim));
        send_frame(FK_OVERRUN, flen, 8'($urandom), 8'($urandom), 1'b1);
      end else if (pick < 73) begin
        send_frame(FK_CUT, flen, 8'($urandom), 8'($urandom), 1'b1);
      end else if (pick < 83) begin
        repeat ($urandom_range(1, 5)) begin
          if ($urandom_range(0, 3) == 0) recv(SYNC_CHAR_1);
          else recv(8'($urandom_range(0, 255)));
        end
      end else begin
        repeat ($urandom_range(1, 4)) send_word(pick_read());
      end
    end
  endtask

  // Hold the sender until every owed reply is back
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.replies_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max_length(input logic [15:0] v);
    drain();
    cfg_valid      <= 1'b1;
    cfg_max_length <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.max_len = v;
    settings++;
  endtask

  // Reply side: random stall bursts, plus long hold-offs on request
  initial begin : reply_sink
    int burst_left, hold_left;
    burst_left = 0;
    hold_left  = 0;
    out_stall  = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall)
        sb.check_reply(frame_good, msg_class, msg_id, msg_length, field_value);
      if (hold_left > 0) begin
        hold_left--;
      end else if (holds_done != holds_asked) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end else if (burst_left > 0) begin
        burst_left--;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        burst_left = $urandom_range(1, 6);
      end
      out_stall <= (hold_left > 0) || (burst_left > 0);
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready) ||
          (!in_valid && !cfg_valid && sb.replies_due.size() == 0))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    word_op        = OP_RECV;
    in_byte        = '0;
    field_offset   = '0;
    field_size     = '0;
    field_signed   = 1'b0;
    cfg_valid      = 1'b0;
    cfg_max_length = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: bad second sync, empty frame, short frame, rejected length, field reads
    recv(SYNC_CHAR_1);
    recv(SYNC_CHAR_1);
    send_frame(FK_GOOD, 16'd0, 8'hFF, 8'h00, 1'b0);
    send_frame(FK_GOOD, 16'd2, 8'h01, 8'h07, 1'b0);
    send_frame(FK_REJECT, MAX_LENGTH_RESET, 8'h0A, 8'hFE, 1'b0);
    read_at(7'd0, 3'd2, 1'b1);
    read_at(7'd1, 3'd1, 1'b0);
    read_at(7'd5, 3'd0, 1'b1);

    // Fill the whole store while replies are held back, then read past its end
    write_max_length(16'hFFFF);
    holds_asked++;
    send_frame(FK_GOOD, 16'(PAYLOAD), 8'($urandom), 8'($urandom), 1'b0);
    read_at(7'd127, 3'd4, 1'b1);
    read_at(7'd124, 3'd4, 1'b0);
    read_at(7'd126, 3'd2, 1'b1);
    send_frame(FK_OVERRUN, 16'd200, 8'($urandom), 8'($urandom), 1'b1);
    send_frame(FK_REJECT, 16'hFFFF, 8'($urandom), 8'($urandom), 1'b1);
    run_traffic(180);

    write_max_length(16'd1);
    run_traffic(120);

    write_max_length(MAX_LENGTH_RESET);
    calm = 1'b1;
    run_traffic(200);
    calm = 1'b0;

    write_max_length(16'($urandom_range(2, 200)));
    holds_asked++;
    run_traffic(200);

    write_max_length(16'd129);
    calm = 1'b1;
    run_traffic(150);

    drain();
    repeat (8) @(posedge clk);
    $display("covered %0d words: %0d field reads, %0d good frames, %0d max_length settings",
             sent, sb.reads, sb.good_frames, settings);
    $display("frames included bad checksums, rejected and overrun lengths and cut streams");
    if (sb.errors == 0 && sb.replies_due.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

/* files.f */
rtl/core/ubxfp_pkg.sv
rtl/core/ubxfp_front.sv
rtl/core/ubxfp_back.sv
rtl/core/ubx_frame_parser.sv
dv/ubx_frame_parser_tb.sv
